/* sv/amt_pkg.sv */
// Shared types and constants for the adaptive mean threshold block.
`default_nettype none
package amt_pkg;
   localparam int PIX_BITS    = 8;
   localparam int RAD_BITS    = 2;
   localparam int WEIGHT_BITS = 9;
   localparam int DIM_BITS    = 11;
   localparam int SUM_BITS    = 14;                  // 49 * 255 fits
   localparam int DIV_CNT_BITS = 4;
   localparam int PROD_BITS   = WEIGHT_BITS + SUM_BITS;
   localparam int CMP_BITS    = PIX_BITS + 8;         // pixel * 256
   localparam int AREA_BITS   = 6;
   localparam int WIN_BITS    = 3;
   localparam int CSR_IDX_BITS = 2;
   localparam int MAX_HEIGHT  = 1024;
   localparam int ROW_BITS    = 10;

   localparam logic [PIX_BITS-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_BITS-1:0] PIX_OFF = 8'd0;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 2'd3;

   localparam logic [RAD_BITS-1:0]    RADIUS_RST = 2'd2;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST = 9'd230;
   localparam logic [DIM_BITS-1:0]    WIDTH_RST  = 11'd640;
   localparam logic [DIM_BITS-1:0]    HEIGHT_RST = 11'd480;

   // Controller to datapath commands
   typedef struct packed {
      logic setup;      // recompute frame size terms
      logic csr_write;
      logic accept;     // input transaction taken
      logic win_step;   // issue one window read
      logic win_flush;  // last accumulate, clear divider
      logic div_step;
      logic mul;
      logic emit;       // load result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic due;        // accepted item yields a result
      logic win_last;
      logic div_last;
   } status_type;
endpackage
`default_nettype wire

/* sv/amt_datapath.sv */
// Datapath: config registers, line store, window sum, divider, compare, result register.
`default_nettype none
module amt_datapath #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire amt_pkg::cmd_type                     cmd,
   output amt_pkg::status_type                       status,
   input  wire logic [amt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [amt_pkg::DIM_BITS-1:0]         csr_data,
   input  wire logic [amt_pkg::PIX_BITS-1:0]         req_pixel,
   input  wire logic                                 req_drain,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic [amt_pkg::PIX_BITS-1:0]              rsp_binary_pixel,
   output logic                                      rsp_frame_last
);
   localparam int RING = 2 * MAX_RADIUS + 2;
   localparam int RB   = $clog2(RING);
   localparam int CB   = $clog2(MAX_WIDTH);
   localparam int WB   = CB + 1;
   localparam int PW   = CB + amt_pkg::DIM_BITS + 1;
   localparam logic [RB-1:0] RING_LAST = RB'(RING - 1);

   // Config registers
   logic [amt_pkg::RAD_BITS-1:0]    radius_ff;
   logic [amt_pkg::WEIGHT_BITS-1:0] weight_ff;
   logic [amt_pkg::DIM_BITS-1:0]    fwidth_ff, fheight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= amt_pkg::RADIUS_RST;
         weight_ff  <= amt_pkg::WEIGHT_RST;
         fwidth_ff  <= amt_pkg::WIDTH_RST;
         fheight_ff <= amt_pkg::HEIGHT_RST;
      end else if (cmd.csr_write) begin
         case (csr_index)
            amt_pkg::CSR_RADIUS: radius_ff  <= csr_data[amt_pkg::RAD_BITS-1:0];
            amt_pkg::CSR_WEIGHT: weight_ff  <= csr_data[amt_pkg::WEIGHT_BITS-1:0];
            amt_pkg::CSR_WIDTH:  fwidth_ff  <= csr_data;
            amt_pkg::CSR_HEIGHT: fheight_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped frame terms
   logic [amt_pkg::RAD_BITS-1:0] rad;
   logic [WB-1:0]                w;
   logic [amt_pkg::DIM_BITS-1:0] h;
   always_comb begin
      rad = (32'(radius_ff) > MAX_RADIUS) ? amt_pkg::RAD_BITS'(MAX_RADIUS) : radius_ff;
      if (fwidth_ff == '0)
         w = WB'(1);
      else if (32'(fwidth_ff) > MAX_WIDTH)
         w = WB'(MAX_WIDTH);
      else
         w = WB'(fwidth_ff);
      if (fheight_ff == '0)
         h = amt_pkg::DIM_BITS'(1);
      else if (32'(fheight_ff) > amt_pkg::MAX_HEIGHT)
         h = amt_pkg::DIM_BITS'(amt_pkg::MAX_HEIGHT);
      else
         h = fheight_ff;
   end

   logic [PW-1:0]                 total_ff, lag_ff;
   logic [amt_pkg::AREA_BITS-1:0] area_ff;
   logic [amt_pkg::WIN_BITS-1:0]  span_ff;   // 2R
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         total_ff <= PW'(w * h);
         lag_ff   <= PW'(w * rad) + PW'(rad);
         span_ff  <= amt_pkg::WIN_BITS'({rad, 1'b0});
         area_ff  <= amt_pkg::AREA_BITS'(({rad, 1'b1}) * ({rad, 1'b1}));
      end
   end

   // Input and output positions
   logic [PW-1:0]        p_ff;
   logic [CB-1:0]        in_col_ff, out_col_ff;
   logic [RB-1:0]        in_ring_ff, out_ring_ff;
   logic [amt_pkg::ROW_BITS-1:0] out_row_ff;
   logic                 in_frame, skip, out_last;
   logic                 restart;

   assign in_frame = p_ff < total_ff;
   assign skip     = in_frame && req_drain;
   assign status.due = !skip && (p_ff >= lag_ff);
   assign out_last = (WB'(out_col_ff) == w - WB'(1)) &&
                     (amt_pkg::DIM_BITS'(out_row_ff) == h - amt_pkg::DIM_BITS'(1));
   assign restart  = cmd.csr_write || (cmd.emit && out_last);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         p_ff        <= '0;
         in_col_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
      end else begin
         if (cmd.accept && !skip) begin
            p_ff <= p_ff + PW'(1);
            if (WB'(in_col_ff) + WB'(1) >= w) begin
               in_col_ff  <= '0;
               in_ring_ff <= (in_ring_ff == RING_LAST) ? '0 : in_ring_ff + RB'(1);
            end else begin
               in_col_ff <= in_col_ff + CB'(1);
            end
         end
         if (cmd.emit) begin
            if (WB'(out_col_ff) + WB'(1) >= w) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + amt_pkg::ROW_BITS'(1);
               out_ring_ff <= (out_ring_ff == RING_LAST) ? '0 : out_ring_ff + RB'(1);
            end else begin
               out_col_ff <= out_col_ff + CB'(1);
            end
         end
      end
   end

   // Window walk counters
   logic [amt_pkg::WIN_BITS-1:0] ai_ff, bi_ff;
   assign status.win_last = (ai_ff == span_ff) && (bi_ff == span_ff);
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ai_ff <= '0;
         bi_ff <= '0;
      end else if (cmd.win_step) begin
         if (bi_ff == span_ff) begin
            bi_ff <= '0;
            ai_ff <= ai_ff + amt_pkg::WIN_BITS'(1);
         end else begin
            bi_ff <= bi_ff + amt_pkg::WIN_BITS'(1);
         end
      end
   end

   // Window tap address and bounds
   logic signed [amt_pkg::DIM_BITS+1:0] rr;
   logic signed [CB+2:0]                cc;
   logic signed [RB+1:0]                rt;
   logic [RB-1:0]                       rd_ring;
   logic                                inb, is_ctr;
   always_comb begin
      rr = $signed({2'b00, 1'b0, out_row_ff}) + $signed({{(amt_pkg::DIM_BITS-1){1'b0}}, ai_ff})
           - $signed({{(amt_pkg::DIM_BITS){1'b0}}, rad});
      cc = $signed({3'b000, out_col_ff}) + $signed({{CB{1'b0}}, ai_ff & 3'b000 | bi_ff})
           - $signed({{(CB+1){1'b0}}, rad});
      rt = $signed({2'b00, out_ring_ff}) + $signed({{(RB-1){1'b0}}, ai_ff})
           - $signed({{RB{1'b0}}, rad});
      if (rt < 0)
         rt = rt + (RB+2)'(RING);
      else if (rt >= (RB+2)'(RING))
         rt = rt - (RB+2)'(RING);
      rd_ring = rt[RB-1:0];
      inb = (rr >= 0) && (rr < $signed({2'b00, h})) &&
            (cc >= 0) && (cc < $signed({2'b00, w}));
      is_ctr = (ai_ff == amt_pkg::WIN_BITS'(rad)) && (bi_ff == amt_pkg::WIN_BITS'(rad));
   end

   // Line store
   logic [amt_pkg::PIX_BITS-1:0] row_store [0:RING-1][0:(1<<CB)-1];
   logic [amt_pkg::PIX_BITS-1:0] rd_q_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept && in_frame && !req_drain)
         row_store[in_ring_ff][in_col_ff] <= req_pixel;
      if (cmd.win_step)
         rd_q_ff <= row_store[rd_ring][cc[CB-1:0]];
   end

   logic rdv_ff, ctr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         ctr_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.win_step && inb;
         ctr_ff <= cmd.win_step && is_ctr;
      end
   end

   // Sum, then restoring divide in place: sum_ff ends as the mean
   logic [amt_pkg::SUM_BITS-1:0]     sum_ff;
   logic [amt_pkg::AREA_BITS:0]      rem_ff;
   logic [amt_pkg::DIV_CNT_BITS-1:0] dcnt_ff;
   logic [amt_pkg::PIX_BITS-1:0]     center_ff;
   logic [amt_pkg::AREA_BITS:0]      rem_sh;
   assign rem_sh = {rem_ff[amt_pkg::AREA_BITS-1:0], sum_ff[amt_pkg::SUM_BITS-1]};
   assign status.div_last = dcnt_ff == amt_pkg::DIV_CNT_BITS'(amt_pkg::SUM_BITS - 1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sum_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, area_ff}) begin
            rem_ff <= rem_sh - {1'b0, area_ff};
            sum_ff <= {sum_ff[amt_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            sum_ff <= {sum_ff[amt_pkg::SUM_BITS-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + amt_pkg::DIV_CNT_BITS'(1);
      end else if (rdv_ff) begin
         sum_ff <= sum_ff + amt_pkg::SUM_BITS'(rd_q_ff);
      end
      if (cmd.win_flush) begin
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (ctr_ff)
         center_ff <= rd_q_ff;
   end

   // Weight times mean
   logic [amt_pkg::PROD_BITS-1:0] prod_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul)
         prod_ff <= amt_pkg::PROD_BITS'(weight_ff * sum_ff);
   end

   // Result register
   logic                         rsp_valid_ff, rsp_last_ff;
   logic [amt_pkg::PIX_BITS-1:0] rsp_pix_ff;
   logic                         above;
   assign above = amt_pkg::PROD_BITS'({center_ff, 8'h00}) > prod_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_pix_ff  <= above ? amt_pkg::PIX_ON : amt_pkg::PIX_OFF;
         rsp_last_ff <= out_last;
      end
   end
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binary_pixel = rsp_pix_ff;
   assign rsp_frame_last   = rsp_last_ff;

   // Checks
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready)) else $error("result overwritten");
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff) else $error("result valid after reset");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (!cmd.win_step && !cmd.div_step && !cmd.emit))
      else $error("accept during busy work");
   a_div_after_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.win_flush |=> !rdv_ff) else $error("late window read");
endmodule
`default_nettype wire

/* sv/amt_ctrl.sv */
// Controller: sequences accept, window sum, divide, multiply and result hand-off.
`default_nettype none
module amt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire amt_pkg::status_type  status,
   output amt_pkg::cmd_type          cmd
);
   typedef enum logic [2:0] {
      ST_SETUP, ST_IDLE, ST_SUM, ST_FLUSH, ST_DIV, ST_MUL, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      slot_free;

   assign slot_free = !rsp_valid || rsp_ready;
   assign csr_ready = state_ff == ST_IDLE;
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_valid) begin
               cmd.csr_write = 1'b1;
               state_in      = ST_SETUP;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.due)
                  state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.win_step = 1'b1;
            if (status.win_last)
               state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.win_flush = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last)
               state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_SETUP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.setup, cmd.csr_write, cmd.accept, cmd.win_step,
                cmd.win_flush, cmd.div_step, cmd.mul, cmd.emit}))
      else $error("overlapping commands");
   a_setup_after_csr: assert property (@(posedge clock) disable iff (reset)
      cmd.csr_write |=> cmd.setup) else $error("setup missed after csr write");
   a_sum_after_due: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.due) |=> cmd.win_step) else $error("window walk missed");
endmodule
`default_nettype wire

/* sv/adaptive_mean_threshold.sv */
// Top level of the adaptive mean threshold binarizer.
//
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_ready   req_pixel[7:0], req_drain
//  rsp_     out        rsp_valid/rsp_ready   rsp_binary_pixel[7:0], rsp_frame_last
//  csr_     in         csr_valid/csr_ready   csr_index[1:0], csr_data[10:0]
//
// An item that yields no result is only accepted. An item that yields a result then
// passes window sum, divide and multiply: the window is read from the single-port line
// store one tap per cycle, then a 14-step restoring divider forms the mean.
// Reset (synchronous) restores the register defaults; a setup step follows reset
// and each csr write. A stalled rsp_ in holds the block in its last step only.
`default_nettype none
module adaptive_mean_threshold #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [amt_pkg::PIX_BITS-1:0]         req_pixel,
   input  wire logic                                 req_drain,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [amt_pkg::PIX_BITS-1:0]              rsp_binary_pixel,
   output logic                                      rsp_frame_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [amt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [amt_pkg::DIM_BITS-1:0]         csr_data
);
   amt_pkg::cmd_type    cmd;
   amt_pkg::status_type status;

   amt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   amt_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel        (req_pixel),
      .req_drain        (req_drain),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_binary_pixel (rsp_binary_pixel),
      .rsp_frame_last   (rsp_frame_last)
   );
endmodule
`default_nettype wire
